### hw/rtl/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg - framed command receiver shared definitions
// Status codes, register map and the word passed from parser to scaler.
// ----------------------------------------------------------------------------
package fcr_pkg;

    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int STEPS_W = 16;
    localparam int PCT_W   = 7;
    localparam int PROD_W  = PCT_W + STEPS_W;

    typedef logic [2:0]         t_status;
    typedef logic [STEPS_W-1:0] t_steps;
    typedef logic [PCT_W-1:0]   t_pct;
    typedef logic [PROD_W-1:0]  t_prod;
    typedef logic [ADDR_W-3:0]  t_reg_idx;

    localparam t_status ST_NONE     = 3'd0;
    localparam t_status ST_REPLY_OK = 3'd1;
    localparam t_status ST_REPLY_ER = 3'd2;
    localparam t_status ST_ACCEPT   = 3'd3;
    localparam t_status ST_OTHER    = 3'd4;
    localparam t_status ST_CSUM_BAD = 3'd5;
    localparam t_status ST_OVER     = 3'd6;
    localparam t_status ST_CLOSED   = 3'd7;

    localparam t_reg_idx REG_MAX_STEPS = t_reg_idx'(0);

    typedef struct packed {
        logic    valid;
        t_status status;
        t_pct    percent;
        t_prod   product;
    } t_mid;

endpackage

### hw/rtl/fcr_ifs.sv
// ----------------------------------------------------------------------------
// fcr_ifs - framed command receiver channels
// Valid/ready channels for received words and for results.
// ----------------------------------------------------------------------------
interface fcr_in_if;
    import fcr_pkg::*;

    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, command, rx_byte, input ready);
    modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface fcr_out_if;
    import fcr_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_steps  target_position;
    t_pct    percent_value;

    modport source (output valid, status, target_position, percent_value, input ready);
    modport sink   (input valid, status, target_position, percent_value, output ready);
endinterface

### hw/rtl/fcr_regs.sv
// ----------------------------------------------------------------------------
// fcr_regs - configuration register bank
// APB-style access to the full-travel step count.
// ----------------------------------------------------------------------------
module fcr_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [fcr_pkg::ADDR_W-1:0] i_paddr,
    input  logic [fcr_pkg::DATA_W-1:0] i_pwdata,
    output logic [fcr_pkg::DATA_W-1:0] o_prdata,
    output logic                      o_pready,
    output fcr_pkg::t_steps           o_max_steps
);
    import fcr_pkg::*;

    t_steps   r_max_steps;
    t_reg_idx w_idx;
    logic     w_wr;

    assign o_pready = 1'b1;
    assign w_idx    = i_paddr[ADDR_W-1:2];
    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_steps <= '0;
        end else if (w_wr && (w_idx == REG_MAX_STEPS)) begin
            r_max_steps <= i_pwdata[STEPS_W-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (w_idx == REG_MAX_STEPS) begin
            o_prdata = DATA_W'(r_max_steps);
        end
    end

    assign o_max_steps = r_max_steps;
endmodule

### hw/rtl/fcr_parser.sv
// ----------------------------------------------------------------------------
// fcr_parser - reply matcher and frame parser
// Registers each word, advances the link state and forms the status word.
// ----------------------------------------------------------------------------
module fcr_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fcr_in_if.sink          in_ch,
    input  fcr_pkg::t_steps i_max_steps,
    output fcr_pkg::t_mid   o_mid,
    input  logic            i_mid_ready
);
    import fcr_pkg::*;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_K      = 8'h4B;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic signed [15:0] VAL_MAX = 16'sd100;

    localparam logic [3:0] RM_IDLE     = 4'd0;
    localparam logic [3:0] RM_E        = 4'd1;
    localparam logic [3:0] RM_ER       = 4'd2;
    localparam logic [3:0] RM_ERR      = 4'd3;
    localparam logic [3:0] RM_ERRO     = 4'd4;
    localparam logic [3:0] RM_ERROR    = 4'd5;
    localparam logic [3:0] RM_ERROR_CR = 4'd6;
    localparam logic [3:0] RM_O        = 4'd10;
    localparam logic [3:0] RM_OK       = 4'd11;
    localparam logic [3:0] RM_OK_CR    = 4'd12;

    localparam logic [3:0] FS_START  = 4'd0;
    localparam logic [3:0] FS_DEVICE = 4'd1;
    localparam logic [3:0] FS_HUND   = 4'd2;
    localparam logic [3:0] FS_TENS   = 4'd3;
    localparam logic [3:0] FS_UNITS  = 4'd4;
    localparam logic [3:0] FS_CHECK  = 4'd5;
    localparam logic [3:0] FS_CL_L   = 4'd6;
    localparam logic [3:0] FS_CL_O   = 4'd7;
    localparam logic [3:0] FS_CL_S   = 4'd8;
    localparam logic [3:0] FS_CL_E   = 4'd9;
    localparam logic [3:0] FS_CL_D   = 4'd10;

    logic       r_in_valid, r_cmd;
    logic [7:0] r_byte;
    logic [3:0] r_reply, n_reply, r_frame, n_frame;
    logic       r_link, n_link, r_stop, n_stop;
    logic [7:0] r_dev, n_dev, r_h, n_h, r_t, n_t, r_u, n_u;
    logic [7:0] r_xor, n_xor, r_acc, n_acc;
    t_mid       r_mid, n_mid;
    t_status    w_status;
    t_pct       w_pct;
    logic       w_s1_en, w_in_ready, w_fire, w_val_ok;
    logic signed [15:0] w_val;
    logic [7:0] w_digit;

    assign w_s1_en    = !r_mid.valid || i_mid_ready;
    assign w_in_ready = !r_in_valid || w_s1_en;
    assign w_fire     = r_in_valid && w_s1_en;
    assign in_ch.ready = w_in_ready;

    // decoded value at full precision, digits may be any byte
    assign w_val = (signed'({8'd0, r_h}) - signed'({8'd0, CH_ZERO})) * 16'sd100
                 + (signed'({8'd0, r_t}) - signed'({8'd0, CH_ZERO})) * 16'sd10
                 + (signed'({8'd0, r_u}) - signed'({8'd0, CH_ZERO}));
    assign w_val_ok = !w_val[15] && (w_val <= VAL_MAX);
    assign w_digit  = r_byte - CH_ZERO;

    always_comb begin
        n_reply  = r_reply;
        n_frame  = r_frame;
        n_link   = r_link;
        n_stop   = r_stop;
        n_dev    = r_dev;
        n_h      = r_h;
        n_t      = r_t;
        n_u      = r_u;
        n_xor    = r_xor;
        n_acc    = r_acc;
        w_status = ST_NONE;
        w_pct    = '0;
        if (r_cmd) begin
            n_link = 1'b1;
        end else if (!r_link) begin
            n_reply = RM_IDLE;
            case (r_reply)
                RM_E:        n_reply = (r_byte == CH_R)  ? RM_ER       : RM_IDLE;
                RM_ER:       n_reply = (r_byte == CH_R)  ? RM_ERR      : RM_IDLE;
                RM_ERR:      n_reply = (r_byte == CH_O)  ? RM_ERRO     : RM_IDLE;
                RM_ERRO:     n_reply = (r_byte == CH_R)  ? RM_ERROR    : RM_IDLE;
                RM_ERROR:    n_reply = (r_byte == CH_CR) ? RM_ERROR_CR : RM_IDLE;
                RM_ERROR_CR: if (r_byte == CH_LF) w_status = ST_REPLY_ER;
                RM_O:        n_reply = (r_byte == CH_K)  ? RM_OK       : RM_IDLE;
                RM_OK:       n_reply = (r_byte == CH_CR) ? RM_OK_CR    : RM_IDLE;
                RM_OK_CR:    if (r_byte == CH_LF) w_status = ST_REPLY_OK;
                default: begin
                    if (r_byte == CH_O) n_reply = RM_O;
                    if (r_byte == CH_E) n_reply = RM_E;
                end
            endcase
        end else begin
            case (r_frame)
                FS_DEVICE: begin
                    n_dev   = r_byte;
                    n_xor   = r_byte;
                    n_frame = FS_HUND;
                end
                FS_HUND: begin
                    n_h     = r_byte;
                    n_xor   = r_xor ^ r_byte;
                    n_frame = FS_TENS;
                end
                FS_TENS: begin
                    n_t     = r_byte;
                    n_xor   = r_xor ^ r_byte;
                    n_frame = FS_UNITS;
                end
                FS_UNITS: begin
                    n_u     = r_byte;
                    n_xor   = r_xor ^ r_byte;
                    n_frame = FS_CHECK;
                end
                FS_CHECK: begin
                    if (r_byte == CH_DOLLAR) begin
                        n_frame = FS_START;
                        if (r_dev != CH_C) begin
                            w_status = ST_OTHER;
                        end else if (r_xor != r_acc) begin
                            w_status = ST_CSUM_BAD;
                        end else if (!w_val_ok) begin
                            w_status = ST_OVER;
                        end else begin
                            w_status = ST_ACCEPT;
                            w_pct    = w_val[PCT_W-1:0];
                        end
                    end else if (!r_stop) begin
                        // decimal accumulate, wrapping at eight bits
                        if (r_byte inside {[CH_ZERO:CH_NINE]}) begin
                            n_acc = {r_acc[4:0], 3'b000} + {r_acc[6:0], 1'b0} + w_digit;
                        end else begin
                            n_stop = 1'b1;
                        end
                    end
                end
                FS_CL_L: n_frame = (r_byte == CH_L) ? FS_CL_O : FS_START;
                FS_CL_O: n_frame = (r_byte == CH_O) ? FS_CL_S : FS_START;
                FS_CL_S: n_frame = (r_byte == CH_S) ? FS_CL_E : FS_START;
                FS_CL_E: n_frame = (r_byte == CH_E) ? FS_CL_D : FS_START;
                FS_CL_D: begin
                    n_frame = FS_START;
                    if (r_byte == CH_D) begin
                        n_link   = 1'b0;
                        w_status = ST_CLOSED;
                    end
                end
                default: begin
                    n_frame = FS_START;
                    if (r_byte == CH_HASH) begin
                        n_frame = FS_DEVICE;
                        n_acc   = '0;
                        n_stop  = 1'b0;
                    end
                    if (r_byte == CH_C) n_frame = FS_CL_L;
                end
            endcase
        end
    end

    always_comb begin
        n_mid.valid   = r_in_valid;
        n_mid.status  = w_status;
        n_mid.percent = w_pct;
        n_mid.product = PROD_W'(w_pct) * PROD_W'(i_max_steps);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cmd      <= 1'b0;
            r_byte     <= '0;
            r_reply    <= RM_IDLE;
            r_frame    <= FS_START;
            r_link     <= 1'b0;
            r_stop     <= 1'b0;
            r_dev      <= '0;
            r_h        <= '0;
            r_t        <= '0;
            r_u        <= '0;
            r_xor      <= '0;
            r_acc      <= '0;
            r_mid      <= '0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= in_ch.valid;
                r_cmd      <= in_ch.command;
                r_byte     <= in_ch.rx_byte;
            end
            if (w_fire) begin
                r_reply <= n_reply;
                r_frame <= n_frame;
                r_link  <= n_link;
                r_stop  <= n_stop;
                r_dev   <= n_dev;
                r_h     <= n_h;
                r_t     <= n_t;
                r_u     <= n_u;
                r_xor   <= n_xor;
                r_acc   <= n_acc;
            end
            if (w_s1_en) begin
                r_mid <= n_mid;
            end
        end
    end

    assign o_mid = r_mid;
endmodule

### hw/rtl/fcr_scaler.sv
// ----------------------------------------------------------------------------
// fcr_scaler - percent to step scaling and result register
// Divides the step product by one hundred and holds the result word.
// ----------------------------------------------------------------------------
module fcr_scaler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fcr_pkg::t_mid i_mid,
    output logic          o_mid_ready,
    fcr_out_if.source     out_ch
);
    import fcr_pkg::*;

    // floor(p / 100) = (p * ceil(2^30 / 100)) >> 30, exact for p below 2^30 / 76
    localparam int RECIP_SH = 30;
    localparam int RECIP_W  = 24;
    localparam int SCALED_W = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SH) + 64'd99) / 64'd100);

    logic                r_valid;
    t_status             r_status;
    t_steps              r_target;
    t_pct                r_pct;
    logic                w_take;
    logic [SCALED_W-1:0] w_scaled;

    assign w_take      = !r_valid || out_ch.ready;
    assign o_mid_ready = w_take;
    assign w_scaled    = SCALED_W'(i_mid.product) * SCALED_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_status <= ST_NONE;
            r_target <= '0;
            r_pct    <= '0;
        end else if (w_take) begin
            r_valid  <= i_mid.valid;
            r_status <= i_mid.status;
            r_target <= w_scaled[RECIP_SH +: STEPS_W];
            r_pct    <= i_mid.percent;
        end
    end

    assign out_ch.valid           = r_valid;
    assign out_ch.status          = r_status;
    assign out_ch.target_position = r_target;
    assign out_ch.percent_value   = r_pct;
endmodule

### hw/rtl/framed_command_receiver.sv
// ----------------------------------------------------------------------------
// framed_command_receiver - reply matcher and framed position command parser
// Watches for OK/ERROR replies until linked, then parses position frames.
// ----------------------------------------------------------------------------
// Path: a taken word lands in the input register, then passes the parse
//   register and the result register before its result shows.
// Throughput: one word per cycle, barring result stalls; the parse register
//   holds link and frame state, so each word sees the state its predecessor left.
// Reset: synchronous, active low; clears matcher, parser, link and max_steps.
// ----------------------------------------------------------------------------
module framed_command_receiver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    fcr_in_if.sink                     i_cmd_ch,
    fcr_out_if.source                  o_res_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fcr_pkg::ADDR_W-1:0] paddr,
    input  logic [fcr_pkg::DATA_W-1:0] pwdata,
    output logic [fcr_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import fcr_pkg::*;

    t_steps w_max_steps;
    t_mid   w_mid;
    logic   w_mid_ready;

    // register bank: max_steps only; the user must write it only while the pipe is idle, the block does not enforce it
    fcr_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_prdata    (prdata),
        .o_pready    (pready),
        .o_max_steps (w_max_steps)
    );

    // parse stage: advance the reply matcher or frame parser one word,
    // and form value * max_steps for an accepted frame
    fcr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (i_cmd_ch),
        .i_max_steps (w_max_steps),
        .o_mid       (w_mid),
        .i_mid_ready (w_mid_ready)
    );

    // scale stage: divide by one hundred, hold the word until taken
    fcr_scaler u_scaler (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid       (w_mid),
        .o_mid_ready (w_mid_ready),
        .out_ch      (o_res_ch)
    );

    // position fields are zero unless a frame is accepted
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && (o_res_ch.status != ST_ACCEPT)) |->
        ((o_res_ch.target_position == '0) && (o_res_ch.percent_value == '0)))
        else $error("position fields set on a non-accept result");

    // an accepted frame never exceeds full travel
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && (o_res_ch.status == ST_ACCEPT)) |->
        ((o_res_ch.percent_value <= PCT_W'(100)) &&
         (o_res_ch.target_position <= w_max_steps)))
        else $error("accepted frame out of range");

    // a parse word held back by the result register keeps its product and status
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mid.valid && !w_mid_ready) |=>
        (w_mid.valid && (w_mid.product == $past(w_mid.product)) &&
         (w_mid.status == $past(w_mid.status))))
        else $error("stalled parse word changed");
endmodule

### bench/tb_framed_command_receiver.sv
// ----------------------------------------------------------------------------
// tb_framed_command_receiver - self-checking bench for the framed receiver
// Streams reply text, link commands, position frames and noise into the block,
// predicts every result word in a scoreboard of its own and compares each
// word taken from the result channel, under random stalls on both sides and
// several max_steps settings written over the register port.
// ----------------------------------------------------------------------------
module tb_framed_command_receiver;
    import fcr_pkg::*;

    // Run control: idle cycles tolerated before giving up, receiver hold-off
    // length, settle time after the last result.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 64;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 10;
    localparam int PHASE_WORDS    = 100;
    localparam int PHASE_COUNT    = 5;

    localparam logic [7:0] CH_HASH   = "#";
    localparam logic [7:0] CH_DOLLAR = "$";
    localparam logic [7:0] CH_C      = "C";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_NINE   = "9";
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef enum logic [3:0] {
        PF_START, PF_DEVICE, PF_HUND, PF_TENS, PF_UNITS, PF_CHECK,
        PF_CL_L, PF_CL_O, PF_CL_S, PF_CL_E, PF_CL_D
    } t_frame_st;

    typedef enum logic [3:0] {
        RM_IDLE     = 4'd0,
        RM_E        = 4'd1,
        RM_ER       = 4'd2,
        RM_ERR      = 4'd3,
        RM_ERRO     = 4'd4,
        RM_ERROR    = 4'd5,
        RM_ERROR_CR = 4'd6,
        RM_O        = 4'd10,
        RM_OK       = 4'd11,
        RM_OK_CR    = 4'd12
    } t_reply_st;

    typedef enum {CS_GOOD, CS_WRAP, CS_PAD, CS_TAIL, CS_BAD, CS_NONE} t_csum_mode;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } t_word;

    typedef struct packed {
        t_status status;
        t_steps  target_position;
        t_pct    percent_value;
    } t_result;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks matcher, parser and link state, holds the results
    // still owed by the block and checks each one as it leaves.
    // ------------------------------------------------------------------------
    class fcr_scoreboard;
        t_steps     max_steps;
        t_reply_st  reply_st;
        t_frame_st  frame_st;
        bit         link_up;
        logic [7:0] dev_byte, hund, tens, units, frame_xor, csum_acc;
        bit         csum_stopped;
        t_result    owed[$];
        int         n_errors;

        function new();
            max_steps    = '0;
            reply_st     = RM_IDLE;
            frame_st     = PF_START;
            link_up      = 1'b0;
            dev_byte     = '0;
            hund         = '0;
            tens         = '0;
            units        = '0;
            frame_xor    = '0;
            csum_acc     = '0;
            csum_stopped = 1'b0;
            n_errors     = 0;
        endfunction

        function t_status match_reply(logic [7:0] b);
            t_status st;
            st = ST_NONE;
            case (reply_st)
                RM_E:     reply_st = (b == "R") ? RM_ER : RM_IDLE;
                RM_ER:    reply_st = (b == "R") ? RM_ERR : RM_IDLE;
                RM_ERR:   reply_st = (b == "O") ? RM_ERRO : RM_IDLE;
                RM_ERRO:  reply_st = (b == "R") ? RM_ERROR : RM_IDLE;
                RM_ERROR: reply_st = (b == CH_CR) ? RM_ERROR_CR : RM_IDLE;
                RM_ERROR_CR: begin
                    if (b == CH_LF) st = ST_REPLY_ER;
                    reply_st = RM_IDLE;
                end
                RM_O:     reply_st = (b == "K") ? RM_OK : RM_IDLE;
                RM_OK:    reply_st = (b == CH_CR) ? RM_OK_CR : RM_IDLE;
                RM_OK_CR: begin
                    if (b == CH_LF) st = ST_REPLY_OK;
                    reply_st = RM_IDLE;
                end
                default: begin
                    reply_st = RM_IDLE;
                    if (b == "O") reply_st = RM_O;
                    if (b == "E") reply_st = RM_E;
                end
            endcase
            return st;
        endfunction

        // Judge a complete frame: device first, then checksum, then range.
        function t_result close_frame();
            t_result r;
            int      val;
            r = '0;
            val = (int'(hund) - 48) * 100 + (int'(tens) - 48) * 10 + (int'(units) - 48);
            if (dev_byte != CH_C) begin
                r.status = ST_OTHER;
            end else if (frame_xor != csum_acc) begin
                r.status = ST_CSUM_BAD;
            end else if (val < 0 || val > 100) begin
                r.status = ST_OVER;
            end else begin
                r.status          = ST_ACCEPT;
                r.percent_value   = t_pct'(val);
                r.target_position = t_steps'((val * int'(max_steps)) / 100);
            end
            return r;
        endfunction

        function t_result parse_frame(logic [7:0] b);
            t_result r;
            r = '0;
            case (frame_st)
                PF_DEVICE: begin
                    dev_byte = b; frame_xor = b; frame_st = PF_HUND;
                end
                PF_HUND: begin
                    hund = b; frame_xor ^= b; frame_st = PF_TENS;
                end
                PF_TENS: begin
                    tens = b; frame_xor ^= b; frame_st = PF_UNITS;
                end
                PF_UNITS: begin
                    units = b; frame_xor ^= b; frame_st = PF_CHECK;
                end
                PF_CHECK: begin
                    if (b == CH_DOLLAR) begin
                        frame_st = PF_START;
                        r = close_frame();
                    end else if (!csum_stopped) begin
                        if (b >= CH_ZERO && b <= CH_NINE)
                            csum_acc = 8'(int'(csum_acc) * 10 + int'(b - CH_ZERO));
                        else
                            csum_stopped = 1'b1;
                    end
                end
                PF_CL_L: frame_st = (b == "L") ? PF_CL_O : PF_START;
                PF_CL_O: frame_st = (b == "O") ? PF_CL_S : PF_START;
                PF_CL_S: frame_st = (b == "S") ? PF_CL_E : PF_START;
                PF_CL_E: frame_st = (b == "E") ? PF_CL_D : PF_START;
                PF_CL_D: begin
                    frame_st = PF_START;
                    if (b == "D") begin
                        link_up  = 1'b0;
                        r.status = ST_CLOSED;
                    end
                end
                default: begin
                    frame_st = PF_START;
                    if (b == CH_HASH) begin
                        frame_st     = PF_DEVICE;
                        csum_acc     = '0;
                        csum_stopped = 1'b0;
                    end
                    if (b == CH_C) frame_st = PF_CL_L;
                end
            endcase
            return r;
        endfunction

        function t_result predict(bit cmd, logic [7:0] b);
            t_result r;
            r = '0;
            if (cmd)
                link_up = 1'b1;
            else if (!link_up)
                r.status = match_reply(b);
            else
                r = parse_frame(b);
            return r;
        endfunction

        function void note_word(t_word w);
            owed.push_back(predict(w.command, w.rx_byte));
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            n_errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("result status %0d with nothing owed", got.status));
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.target_position !== want.target_position)
                report_mismatch($sformatf("target_position %0d, want %0d",
                                          got.target_position, want.target_position));
            if (got.percent_value !== want.percent_value)
                report_mismatch($sformatf("percent_value %0d, want %0d",
                                          got.percent_value, want.percent_value));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block itself
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                psel, penable, pwrite, pready;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata, prdata;

    fcr_in_if  cmd_ch ();
    fcr_out_if res_ch ();

    framed_command_receiver i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_ch),
        .o_res_ch (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // sb checks the block; plan runs ahead of it at generation time so the
    // sequence picker knows whether the link will be up.
    fcr_scoreboard sb   = new();
    fcr_scoreboard plan = new();

    t_word burst[$];
    bit    hold_req   = 1'b0;
    bit    tx_idle_on = 1'b1;
    bit    rx_idle_on = 1'b1;
    int    stall_left = 0;
    int    idle_cycles = 0;

    // Mostly back to back, often a short gap, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Monitors: note every word the block takes, check every word it gives.
    // Both sample pre-edge values, so they agree with the block on each edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready)
            sb.note_word('{command: cmd_ch.command, rx_byte: cmd_ch.rx_byte});
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result('{status:          res_ch.status,
                              target_position: res_ch.target_position,
                              percent_value:   res_ch.percent_value});
    end

    // Watchdog: end the run if neither channel moves a word for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off on request, counted
    // here so the sender keeps pushing words while the block backs up.
    // ------------------------------------------------------------------------
    initial begin
        int g;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else if (hold_req) begin
                hold_req     = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end else if (!rx_idle_on) begin
                res_ch.ready <= 1'b1;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    stall_left   = g - 1;
                    res_ch.ready <= 1'b0;
                end else begin
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------

    // Write one register (setup, access), then read it back the same way.
    task automatic write_reg(t_reg_idx idx, logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[STEPS_W-1:0] !== val[STEPS_W-1:0])
            sb.report_mismatch($sformatf("register %0d reads %0h, written %0h",
                                         idx, prdata, val));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_max_steps(t_steps v);
        write_reg(REG_MAX_STEPS, DATA_W'(v));
        sb.max_steps   = v;
        plan.max_steps = v;
    endtask

    // ------------------------------------------------------------------------
    // Word source
    // ------------------------------------------------------------------------

    // Offer one word, hold it until taken, then maybe drop valid for a gap.
    task automatic send_word(t_word w);
        int g;
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= w.command;
        cmd_ch.rx_byte <= w.rx_byte;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        if (tx_idle_on) begin
            g = gap_len();
            if (g > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    endtask

    task automatic flush_burst();
        while (burst.size() != 0) send_word(burst.pop_front());
    endtask

    // Drop valid and hold until every owed result has left the block.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Sequence building
    // ------------------------------------------------------------------------
    function automatic void push_word(bit cmd, logic [7:0] b);
        t_word w;
        w.command = cmd;
        w.rx_byte = b;
        burst.push_back(w);
        void'(plan.predict(cmd, b));
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_word(1'b0, s[i]);
    endfunction

    function automatic logic [7:0] any_but_end();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_DOLLAR);
        return b;
    endfunction

    // A byte that halts checksum digits: sign, blank or any other non-digit.
    function automatic logic [7:0] stop_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0: b = "-";
            1: b = " ";
            2: b = "+";
            default: begin
                do b = 8'($urandom);
                while (b == CH_DOLLAR || (b >= CH_ZERO && b <= CH_NINE));
            end
        endcase
        return b;
    endfunction

    // A whole frame: mostly good, with wrong device, out-of-range or
    // non-digit values and every flavour of checksum mixed in.
    function automatic void push_frame();
        logic [7:0] dev, h, t, u, x;
        int         v, r, n;
        t_csum_mode mode;
        r   = $urandom_range(0, 99);
        dev = (r < 85) ? CH_C : 8'($urandom);
        r   = $urandom_range(0, 99);
        if (r < 10)      v = 0;
        else if (r < 20) v = 100;
        else if (r < 70) v = $urandom_range(0, 100);
        else if (r < 85) v = $urandom_range(101, 999);
        else             v = -1;
        if (v >= 0) begin
            h = 8'(int'(CH_ZERO) + v / 100);
            t = 8'(int'(CH_ZERO) + (v / 10) % 10);
            u = 8'(int'(CH_ZERO) + v % 10);
        end else begin
            h = 8'($urandom);
            t = 8'($urandom);
            u = 8'($urandom);
        end
        x = dev ^ h ^ t ^ u;
        r = $urandom_range(0, 99);
        if (r < 50)      mode = CS_GOOD;
        else if (r < 60) mode = CS_WRAP;
        else if (r < 70) mode = CS_PAD;
        else if (r < 80) mode = CS_TAIL;
        else if (r < 92) mode = CS_BAD;
        else             mode = CS_NONE;
        push_word(1'b0, CH_HASH);
        push_word(1'b0, dev);
        push_word(1'b0, h);
        push_word(1'b0, t);
        push_word(1'b0, u);
        case (mode)
            CS_GOOD: push_text($sformatf("%0d", x));
            // same value modulo 256, more digits
            CS_WRAP: push_text($sformatf("%0d", int'(x) + 256 * $urandom_range(1, 3)));
            CS_PAD:  push_text($sformatf("00%0d", x));
            CS_TAIL: begin
                push_text($sformatf("%0d", x));
                push_word(1'b0, stop_byte());
                n = $urandom_range(0, 3);
                repeat (n) push_word(1'b0, any_but_end());
            end
            CS_BAD:  push_text($sformatf("%0d", 8'(int'(x) + $urandom_range(1, 255))));
            CS_NONE: ;
        endcase
        push_word(1'b0, CH_DOLLAR);
    endfunction

    // Follow a random prefix of a text with an E, an O or a random byte, which may
    // be the expected one; E and O are favoured since the matcher must not restart on them mid-reply.
    function automatic void push_broken(string s);
        int n;
        n = $urandom_range(1, s.len() - 1);
        for (int i = 0; i < n; i++) push_word(1'b0, s[i]);
        case ($urandom_range(0, 2))
            0:       push_word(1'b0, "E");
            1:       push_word(1'b0, "O");
            default: push_word(1'b0, 8'($urandom));
        endcase
    endfunction

    function automatic void push_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) push_word($urandom_range(0, 7) == 0, 8'($urandom));
    endfunction

    // Pick the next sequence from the state the link will be in by then.
    function automatic void build_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (plan.link_up) begin
            if (r < 50)      push_frame();
            else if (r < 60) push_text("CLOSED");
            else if (r < 68) push_broken("CLOSED");
            else if (r < 76) begin
                push_word(1'b0, CH_HASH);
                repeat ($urandom_range(1, 4)) push_word(1'b0, 8'($urandom));
            end
            else if (r < 84) push_noise();
            else if (r < 90) push_word(1'b1, 8'($urandom));
            else             push_text("OK\r\n");
        end else begin
            if (r < 30)      push_text("OK\r\n");
            else if (r < 55) push_text("ERROR\r\n");
            else if (r < 70) push_broken(($urandom_range(0, 1) == 0) ? "OK\r\n" : "ERROR\r\n");
            else if (r < 85) push_word(1'b1, 8'($urandom));
            else             push_noise();
        end
    endfunction

    task automatic run_phase(int n_words);
        int sent;
        sent = 0;
        while (sent < n_words) begin
            build_sequence();
            sent += burst.size();
            flush_burst();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_steps steps;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= 1'b0;
        cmd_ch.rx_byte <= 8'h00;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: both replies, link up twice, a full-scale frame at the
        // widest travel, then close the link.
        write_max_steps(16'hFFFF);
        push_text("OK\r\n");
        push_text("ERROR\r\n");
        push_word(1'b1, 8'h00);
        push_word(1'b1, 8'hFF);
        push_word(1'b0, CH_HASH);
        push_text("C100");
        push_text("114");
        push_word(1'b0, CH_DOLLAR);
        push_text("CLOSED");
        flush_burst();
        wait_drained();

        // Random phases, one travel setting each, drained before each write.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       steps = 16'd0;
                1:       steps = 16'd100;
                2:       steps = t_steps'($urandom);
                3:       steps = 16'd1;
                default: steps = 16'hFFFF;
            endcase
            write_max_steps(steps);
            case (p)
                1: begin
                    // pause the sender until everything owed has come out
                    run_phase(PHASE_WORDS / 2);
                    wait_drained();
                    run_phase(PHASE_WORDS / 2);
                end
                2: begin
                    // hold the result side off while words keep coming
                    hold_req   = 1'b1;
                    tx_idle_on = 1'b0;
                    run_phase(PHASE_WORDS / 2);
                    tx_idle_on = 1'b1;
                    run_phase(PHASE_WORDS / 2);
                end
                3: begin
                    // full rate both ways
                    tx_idle_on = 1'b0;
                    rx_idle_on = 1'b0;
                    run_phase(PHASE_WORDS);
                    tx_idle_on = 1'b1;
                    rx_idle_on = 1'b1;
                end
                default: run_phase(PHASE_WORDS);
            endcase
            wait_drained();
        end

        // Let any stray result show up before judging.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.owed.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.owed.size()));
        if (sb.n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
hw/rtl/fcr_pkg.sv
hw/rtl/fcr_ifs.sv
hw/rtl/fcr_regs.sv
hw/rtl/fcr_parser.sv
hw/rtl/fcr_scaler.sv
hw/rtl/framed_command_receiver.sv
bench/tb_framed_command_receiver.sv
